>>> hw/rtl/gai_pkg.sv
// Shared types and constants of the gyro angle integrator.
package gai_pkg;

    // Angle unit is 1/131072000 degree; 131072000 = 2^20 * 125
    localparam int unsigned ACC_W        = 37;
    localparam longint      UNITS_PER_DEG = 64'd131072000;
    localparam logic signed [ACC_W-1:0] FULL_TURN = 37'sd47185920000;
    localparam logic [35:0] HALF_DEG     = 36'd65536000;
    localparam int unsigned DEG_SHIFT    = 20;
    // floor(v / 125) = (v * RECIP_125) >> RECIP_SHIFT for v below 2^18
    localparam logic [16:0] RECIP_125    = 17'd67109;
    localparam int unsigned RECIP_SHIFT  = 23;

    // Configuration register indexes
    localparam logic [1:0] CFG_OFFSET_X = 2'd0;
    localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
    localparam logic [1:0] CFG_OFFSET_Z = 2'd2;

    typedef struct packed {
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic        [15:0] elapsed_us;
        logic               clear_angles;
    } in_item_t;

    typedef struct packed {
        logic [5:0] tilt_x;
        logic [5:0] tilt_y;
        logic [8:0] heading;
    } out_item_t;

    // Request after offset correction, as held in the queue
    typedef struct packed {
        logic signed [16:0] corr_x;
        logic signed [16:0] corr_y;
        logic signed [16:0] corr_z;
        logic        [15:0] elapsed_us;
        logic               clear_angles;
    } q_item_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

>>> hw/rtl/gai_front.sv
// Front end: offset registers, request acceptance and rate correction.
module gai_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gai_pkg::in_item_t   in_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  gai_pkg::q_status_t  q_status,
    output logic                push,
    output gai_pkg::q_item_t    push_data
);

    logic signed [15:0] offset_x_reg;
    logic signed [15:0] offset_y_reg;
    logic signed [15:0] offset_z_reg;

    // Write calibration offsets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gai_pkg::CFG_OFFSET_X: offset_x_reg <= $signed(cfg_data);
                gai_pkg::CFG_OFFSET_Y: offset_y_reg <= $signed(cfg_data);
                gai_pkg::CFG_OFFSET_Z: offset_z_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Accept while the queue has room
    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    // Subtract offsets at 17 bits so the difference never wraps
    always_comb
    begin
        push_data.corr_x = 17'(in_data.rate_x) - 17'(offset_x_reg);
        push_data.corr_y = 17'(in_data.rate_y) - 17'(offset_y_reg);
        push_data.corr_z = 17'(in_data.rate_z) - 17'(offset_z_reg);
        push_data.elapsed_us   = in_data.elapsed_us;
        push_data.clear_angles = in_data.clear_angles;
    end

endmodule

>>> hw/rtl/gai_queue.sv
// Two-entry request queue between front and back end.
module gai_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gai_pkg::q_item_t    push_data,
    input  logic                pop,
    output gai_pkg::q_item_t    head,
    output gai_pkg::q_status_t  status
);

    gai_pkg::q_item_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    // Store requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != 2'd0);
    assign status.full      = (count_reg == 2'd2);

endmodule

>>> hw/rtl/gai_back.sv
// Back end: rate times time, angle accumulation with wrap, rounding and clamping.
module gai_back #(
    parameter int TILT_LIMIT = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gai_pkg::q_item_t    head,
    input  gai_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output gai_pkg::out_item_t  out_data
);

    localparam int unsigned AW = gai_pkg::ACC_W;
    localparam logic signed [AW-1:0] LIM_UNITS =
        AW'(longint'(TILT_LIMIT) * gai_pkg::UNITS_PER_DEG);
    localparam logic signed [AW-1:0] NEG_LIM_UNITS = -LIM_UNITS;
    localparam logic signed [7:0]    LIM8 = 8'(TILT_LIMIT);

    // Wrap a sum by a truncated remainder of a full turn; heading folds into [0, turn)
    function automatic logic signed [AW-1:0] wrap_turn(
        input logic signed [AW-1:0] sum,
        input logic                 fold
    );
        logic signed [AW-1:0] res;
        res = sum;
        if (sum >= gai_pkg::FULL_TURN)
        begin
            res = sum - gai_pkg::FULL_TURN;
        end
        else if (sum <= -gai_pkg::FULL_TURN)
        begin
            res = sum + gai_pkg::FULL_TURN;
        end
        else if (fold && sum < 0)
        begin
            res = sum + gai_pkg::FULL_TURN;
        end
        return res;
    endfunction

    // Magnitude plus half a degree, in units of 2^20, times the reciprocal of 125
    function automatic logic [32:0] scale_deg(input logic signed [AW-1:0] a);
        logic [AW-1:0] mag;
        logic [35:0]   rnd;
        mag = a[AW-1] ? AW'(-a) : AW'(a);
        rnd = mag[35:0] + gai_pkg::HALF_DEG;
        return 33'(rnd[35:gai_pkg::DEG_SHIFT]) * 33'(gai_pkg::RECIP_125);
    endfunction

    // Signed whole degrees to clamped, offset tilt code
    function automatic logic [5:0] tilt_code(
        input logic [32:0] prod,
        input logic        neg,
        input logic        hi,
        input logic        lo
    );
        logic        [7:0] q;
        logic signed [7:0] t;
        q = prod[gai_pkg::RECIP_SHIFT +: 8];
        t = neg ? -$signed(q) : $signed(q);
        if (hi)
        begin
            t = LIM8;
        end
        else if (lo)
        begin
            t = -LIM8;
        end
        return 6'(t + LIM8);
    endfunction

    logic                 advance;
    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic                 s3_valid_reg;
    logic                 out_valid_reg;
    gai_pkg::out_item_t   out_data_reg;
    gai_pkg::out_item_t   out_data_next;

    logic signed [32:0]   s1_prod_x_reg;
    logic signed [32:0]   s1_prod_y_reg;
    logic signed [32:0]   s1_prod_z_reg;
    logic                 s1_clear_reg;
    logic signed [33:0]   prod_x_full;
    logic signed [33:0]   prod_y_full;
    logic signed [33:0]   prod_z_full;

    logic signed [AW-1:0] acc_x_reg;
    logic signed [AW-1:0] acc_y_reg;
    logic signed [AW-1:0] acc_z_reg;
    logic signed [AW-1:0] acc_x_next;
    logic signed [AW-1:0] acc_y_next;
    logic signed [AW-1:0] acc_z_next;
    logic signed [AW-1:0] base_x;
    logic signed [AW-1:0] base_y;
    logic signed [AW-1:0] base_z;

    logic [32:0]          s3_prod_x_reg;
    logic [32:0]          s3_prod_y_reg;
    logic [32:0]          s3_prod_z_reg;
    logic                 s3_neg_x_reg;
    logic                 s3_neg_y_reg;
    logic                 s3_hi_x_reg;
    logic                 s3_hi_y_reg;
    logic                 s3_lo_x_reg;
    logic                 s3_lo_y_reg;

    // Whole pipeline moves unless a result is held at the output
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && q_status.not_empty;

    // Stage 1: corrected rate times elapsed time
    assign prod_x_full = head.corr_x * $signed({1'b0, head.elapsed_us});
    assign prod_y_full = head.corr_y * $signed({1'b0, head.elapsed_us});
    assign prod_z_full = head.corr_z * $signed({1'b0, head.elapsed_us});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_x_reg <= prod_x_full[32:0];
            s1_prod_y_reg <= prod_y_full[32:0];
            s1_prod_z_reg <= prod_z_full[32:0];
            s1_clear_reg  <= head.clear_angles;
        end
    end

    // Stage 2: accumulate and wrap
    always_comb
    begin
        base_x     = s1_clear_reg ? '0 : acc_x_reg;
        base_y     = s1_clear_reg ? '0 : acc_y_reg;
        base_z     = s1_clear_reg ? '0 : acc_z_reg;
        acc_x_next = wrap_turn(base_x + AW'(s1_prod_x_reg), 1'b0);
        acc_y_next = wrap_turn(base_y + AW'(s1_prod_y_reg), 1'b0);
        acc_z_next = wrap_turn(base_z + AW'(s1_prod_z_reg), 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end
        else if (advance && s1_valid_reg)
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            acc_z_reg <= acc_z_next;
        end
    end

    // Stage 3: scale to degrees and flag the tilt limits
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_prod_x_reg <= scale_deg(acc_x_reg);
            s3_prod_y_reg <= scale_deg(acc_y_reg);
            s3_prod_z_reg <= scale_deg(acc_z_reg);
            s3_neg_x_reg  <= acc_x_reg[AW-1];
            s3_neg_y_reg  <= acc_y_reg[AW-1];
            s3_hi_x_reg   <= (acc_x_reg >= LIM_UNITS);
            s3_hi_y_reg   <= (acc_y_reg >= LIM_UNITS);
            s3_lo_x_reg   <= (acc_x_reg <= NEG_LIM_UNITS);
            s3_lo_y_reg   <= (acc_y_reg <= NEG_LIM_UNITS);
        end
    end

    // Stage 4: form the result
    always_comb
    begin
        out_data_next.tilt_x  = tilt_code(s3_prod_x_reg, s3_neg_x_reg,
                                          s3_hi_x_reg, s3_lo_x_reg);
        out_data_next.tilt_y  = tilt_code(s3_prod_y_reg, s3_neg_y_reg,
                                          s3_hi_y_reg, s3_lo_y_reg);
        out_data_next.heading = s3_prod_z_reg[gai_pkg::RECIP_SHIFT +: 9];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Valid bits of each stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_status.not_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/gyro_angle_integrator_top.sv
// Top level of the gyro angle integrator.
// Integrates three-axis gyro rate requests into angles held exactly in units of
// 1/131072000 degree and returns one result per request: two tilt codes
// clamped to +-TILT_LIMIT degrees plus TILT_LIMIT, and a heading of 0..360.
// A result passes the product, accumulator, scaled and output registers. While
// the queue has room and the output is not stalled, each angle accumulator's
// add-and-wrap loop sets the rate of one request per cycle. A two-entry queue
// between the offset-correcting front end and the multiply, accumulate and
// rounding pipeline lets input and output stall independently. Offsets must be
// written by the user while no request is in flight; not enforced by the block.
module gyro_angle_integrator_top #(
    parameter int TILT_LIMIT = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gai_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gai_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    gai_pkg::q_status_t q_status;
    gai_pkg::q_item_t   push_data;
    gai_pkg::q_item_t   head;
    logic               push;
    logic               pop;

    gai_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    gai_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    gai_back #(
        .TILT_LIMIT (TILT_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> hw/rtl/gai_checker.sv
// Port-level checks of the gyro angle integrator, bound to the top level.
module gai_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  gai_pkg::out_item_t  out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result dropped or changed");

    // No result while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

    // Heading stays within a full turn
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.heading <= 9'd360)
        else $error("heading out of range");

    // No result shows right after reset, before any request could pass the pipeline
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
        else $error("result appeared without a request");

endmodule

bind gyro_angle_integrator_top gai_checker u_gai_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> bench/testbench.sv
// Testbench for the gyro angle integrator: directed and random requests, scoreboard checks.
`timescale 1ns / 100ps

module testbench;

    localparam int     TILT      = 30;
    localparam longint UNITS_DEG = 64'd131072000;
    localparam longint UNITS_REV = 360 * UNITS_DEG;
    localparam int     RANDOM_PER_PHASE = 340;

    // Tracks the three angles and the offsets, and holds the results still due
    class angle_tracker;
        longint    off_x;
        longint    off_y;
        longint    off_z;
        longint    ang_x;
        longint    ang_y;
        longint    ang_z;
        gai_pkg::out_item_t due_results[$];
        int        errors;

        function new();
            off_x = 0;
            off_y = 0;
            off_z = 0;
            ang_x = 0;
            ang_y = 0;
            ang_z = 0;
            errors = 0;
        endfunction

        function void set_offset(logic [1:0] idx, logic [15:0] val);
            case (idx)
                gai_pkg::CFG_OFFSET_X: off_x = longint'($signed(val));
                gai_pkg::CFG_OFFSET_Y: off_y = longint'($signed(val));
                gai_pkg::CFG_OFFSET_Z: off_z = longint'($signed(val));
                default: ;
            endcase
        endfunction

        // Whole degrees, half away from zero
        function longint round_deg(longint a);
            if (a >= 0)
                return (a + UNITS_DEG / 2) / UNITS_DEG;
            return -((-a + UNITS_DEG / 2) / UNITS_DEG);
        endfunction

        // Add corrected rate times dt, then take the truncated remainder of a full turn
        function longint integrate(longint acc, logic [15:0] raw, longint off, longint dt);
            longint corr;
            corr = longint'($signed(raw)) - off;
            acc += corr * dt;
            return acc % UNITS_REV;
        endfunction

        function logic [5:0] tilt_code(longint a);
            longint t;
            if (a >= TILT * UNITS_DEG)
                t = TILT;
            else if (a <= -TILT * UNITS_DEG)
                t = -TILT;
            else
                t = round_deg(a);
            return 6'(t + TILT);
        endfunction

        function void note_sample(gai_pkg::in_item_t s);
            longint    dt;
            gai_pkg::out_item_t res;
            dt = longint'(s.elapsed_us);
            if (s.clear_angles)
            begin
                ang_x = 0;
                ang_y = 0;
                ang_z = 0;
            end
            ang_x = integrate(ang_x, s.rate_x, off_x, dt);
            ang_y = integrate(ang_y, s.rate_y, off_y, dt);
            ang_z = integrate(ang_z, s.rate_z, off_z, dt);
            if (ang_z < 0)
                ang_z += UNITS_REV;
            res.tilt_x  = tilt_code(ang_x);
            res.tilt_y  = tilt_code(ang_y);
            res.heading = 9'(round_deg(ang_z));
            due_results.push_back(res);
        endfunction

        function void check_result(gai_pkg::out_item_t got);
            gai_pkg::out_item_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: result %p with none due", $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.tilt_x !== want.tilt_x)
            begin
                $display("%0t: tilt_x expected %0d actual %0d", $time, want.tilt_x, got.tilt_x);
                errors++;
            end
            if (got.tilt_y !== want.tilt_y)
            begin
                $display("%0t: tilt_y expected %0d actual %0d", $time, want.tilt_y, got.tilt_y);
                errors++;
            end
            if (got.heading !== want.heading)
            begin
                $display("%0t: heading expected %0d actual %0d", $time,
                         want.heading, got.heading);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    gai_pkg::in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    gai_pkg::out_item_t out_data;
    logic      cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    angle_tracker tracker;
    int sent_count;
    int taken_count;
    int hold_left;

    gyro_angle_integrator_top #(
        .TILT_LIMIT(TILT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap before the next request or result; calm stretches have none
    function int draw_gap(int n);
        if ((n / 64) % 4 == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    function logic [15:0] extreme_rate();
        case ($urandom_range(0, 3))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    // Half of the rates near the offset so the tilt stays in range, the rest full-range noise
    function logic [15:0] pick_rate(longint off);
        int m;
        m = $urandom_range(0, 9);
        if (m < 5)
            return 16'(off + $signed($urandom_range(0, 4000)) - 2000);
        if (m < 9)
            return 16'($urandom);
        return extreme_rate();
    endfunction

    function gai_pkg::in_item_t random_sample();
        gai_pkg::in_item_t s;
        int m;
        s.rate_x = pick_rate(tracker.off_x);
        s.rate_y = pick_rate(tracker.off_y);
        s.rate_z = pick_rate(tracker.off_z);
        m = $urandom_range(0, 9);
        if (m < 7)
            s.elapsed_us = 16'($urandom);
        else if (m < 9)
            s.elapsed_us = 16'($urandom_range(0, 300));
        else
            s.elapsed_us = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        s.clear_angles = ($urandom_range(0, 15) == 0);
        return s;
    endfunction

    function gai_pkg::in_item_t make_sample(logic [15:0] rx, logic [15:0] ry,
                                            logic [15:0] rz, logic [15:0] dt, logic clr);
        gai_pkg::in_item_t s;
        s.rate_x = rx;
        s.rate_y = ry;
        s.rate_z = rz;
        s.elapsed_us = dt;
        s.clear_angles = clr;
        return s;
    endfunction

    // Present one request and hold it until taken; called and left at a falling edge
    task send_sample(gai_pkg::in_item_t s);
        int gap;
        gap = draw_gap(sent_count);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = s;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_sample(s);
        sent_count++;
        @(negedge clk);
    endtask

    // Write all three offsets back to back while the block is idle
    task write_offsets(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz);
        logic [15:0] vals [3];
        logic [1:0]  idxs [3];
        vals = '{ox, oy, oz};
        idxs = '{gai_pkg::CFG_OFFSET_X, gai_pkg::CFG_OFFSET_Y, gai_pkg::CFG_OFFSET_Z};
        for (int i = 0; i < 3; i++)
        begin
            cfg_we    = 1'b1;
            cfg_index = idxs[i];
            cfg_data  = vals[i];
            @(posedge clk);
            tracker.set_offset(idxs[i], vals[i]);
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    task drain();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    task run_random(int count);
        for (int i = 0; i < count; i++)
            send_sample(random_sample());
        drain();
    endtask

    // Receiver: drop ready for a drawn number of cycles after each result
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = rst_n;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_result(out_data);
            taken_count++;
            hold_left = draw_gap(taken_count + 32);
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        tracker     = new();
        sent_count  = 0;
        taken_count = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = gai_pkg::CFG_OFFSET_X;
        cfg_data  = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Zero samples, then exactly half a degree each way (heading -0.5 wraps to 360)
        send_sample(make_sample(16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
        send_sample(make_sample(16'd2000, -16'sd2000, -16'sd2000, 16'd32768, 1'b1));
        send_sample(make_sample(16'd1999, -16'sd1999, 16'd2000, 16'd32768, 1'b1));
        // Climb in 7.5 degree steps to exactly the tilt limit, then just past it
        send_sample(make_sample(16'd30000, -16'sd30000, 16'd30000, 16'd32768, 1'b1));
        repeat (3)
            send_sample(make_sample(16'd30000, -16'sd30000, 16'd30000, 16'd32768, 1'b0));
        send_sample(make_sample(16'd1, -16'sd1, -16'sd1, 16'd1, 1'b0));
        // Full-scale rates over the longest interval
        send_sample(make_sample(16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 1'b1));
        send_sample(make_sample(16'h8000, 16'h7fff, 16'h8000, 16'hffff, 1'b0));
        send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'hffff, 1'b0));
        send_sample(make_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 1'b1));
        drain();

        // Extreme offsets: corrected rates reach the 17-bit ends
        write_offsets(16'h7fff, 16'h8000, 16'h7fff);
        send_sample(make_sample(16'h8000, 16'h7fff, 16'h8000, 16'hffff, 1'b1));
        send_sample(make_sample(16'h8000, 16'h7fff, 16'h8000, 16'hffff, 1'b0));
        send_sample(make_sample(16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 1'b1));
        run_random(RANDOM_PER_PHASE);

        write_offsets(16'h8000, 16'h7fff, 16'h8000);
        run_random(RANDOM_PER_PHASE);

        repeat (3)
        begin
            write_offsets(16'($urandom), 16'($urandom), 16'($urandom));
            run_random(RANDOM_PER_PHASE);
        end

        write_offsets(16'h0000, 16'h0000, 16'h0000);
        run_random(RANDOM_PER_PHASE);

        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
